// ===== sv/utf8_decode_line_tracker_defines.svh =====
// assertion macros shared by the decoder modules
`ifndef UTF8_DECODE_LINE_TRACKER_DEFINES_SVH
`define UTF8_DECODE_LINE_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UDLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UDLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/udlt_pkg.sv =====
`default_nettype none

package udlt_pkg;

    // default counter widths
    localparam int OFFSET_WIDTH_DFLT = 32;
    localparam int LINE_WIDTH_DFLT   = 24;
    localparam int COLUMN_WIDTH_DFLT = 16;

    // fixed field widths of a result
    localparam int CP_W      = 21;
    localparam int UNITS_W   = 2;
    localparam int OUT_OFF_W = 32;
    localparam int OUT_LINE_W = 24;
    localparam int OUT_COL_W = 16;
    localparam int CP_SHIFT  = 6;

    // byte ranges
    localparam logic [7:0] ASCII_LAST = 8'h7F;
    localparam logic [7:0] CONT_FIRST = 8'h80;
    localparam logic [7:0] CONT_LAST  = 8'hBF;
    localparam logic [7:0] LEAD2_FIRST = 8'hC0;
    localparam logic [7:0] LEAD2_LAST  = 8'hDF;
    localparam logic [7:0] LEAD3_FIRST = 8'hE0;
    localparam logic [7:0] LEAD3_LAST  = 8'hEF;

    // payload masks
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;

    localparam logic [CP_W-1:0] CP_SUPP = 21'h10000;
    localparam logic [7:0]      LF_CHAR = 8'h0A;

    localparam logic [UNITS_W-1:0] UNITS_BMP  = 2'd1;
    localparam logic [UNITS_W-1:0] UNITS_PAIR = 2'd2;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [2:0] {
        BC_ASCII,
        BC_CONT,
        BC_LEAD2,
        BC_LEAD3,
        BC_LEAD4
    } byte_class_t;

    typedef struct packed {
        logic [CP_W-1:0]       cp_value;
        logic [UNITS_W-1:0]    utf16_units;
        logic [OUT_OFF_W-1:0]  utf8_end_offset;
        logic [OUT_OFF_W-1:0]  utf16_end_offset;
        logic [OUT_LINE_W-1:0] line_number;
        logic [OUT_COL_W-1:0]  utf16_column;
        logic                  is_newline;
        logic                  last_of_run;
    } out_item_t;

    // results written by the decoder in one cycle, in order
    typedef struct packed {
        logic [1:0] n_items;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        unique case (b) inside
            [8'h00:ASCII_LAST]:       c = BC_ASCII;
            [CONT_FIRST:CONT_LAST]:   c = BC_CONT;
            [LEAD2_FIRST:LEAD2_LAST]: c = BC_LEAD2;
            [LEAD3_FIRST:LEAD3_LAST]: c = BC_LEAD3;
            default:                  c = BC_LEAD4;
        endcase
        return c;
    endfunction

    function automatic logic [UNITS_W-1:0] units_of(input logic [CP_W-1:0] cp);
        return (cp >= CP_SUPP) ? UNITS_PAIR : UNITS_BMP;
    endfunction

endpackage

`default_nettype wire

// ===== sv/udlt_ifs.sv =====
`default_nettype none

interface udlt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface udlt_point_if;
    logic        valid;
    logic        ready;
    logic [20:0] cp_value;
    logic [1:0]  utf16_units;
    logic [31:0] utf8_end_offset;
    logic [31:0] utf16_end_offset;
    logic [23:0] line_number;
    logic [15:0] utf16_column;
    logic        is_newline;
    logic        last_of_run;

    modport source (
        output valid, output cp_value, output utf16_units, output utf8_end_offset,
        output utf16_end_offset, output line_number, output utf16_column,
        output is_newline, output last_of_run, input ready
    );
    modport sink (
        input valid, input cp_value, input utf16_units, input utf8_end_offset,
        input utf16_end_offset, input line_number, input utf16_column,
        input is_newline, input last_of_run, output ready
    );
endinterface

`default_nettype wire

// ===== sv/utf8_decode_line_tracker.sv =====
// utf-8 decoder with position tracking. each transaction on text_byte carries one raw
// byte; each transaction on code_item carries one decoded code point with its utf-16
// unit count, the utf-8 byte offset and utf-16 unit offset just after it, and the line
// and utf-16 column after it. a byte yields zero, one or two code points; the last one
// it yields has last_of_run set. throughput is one byte per cycle while each byte
// yields at most one code point and the sink takes a result every cycle; a byte that
// yields two results occupies the single result port for two transactions. a byte's
// first result passes through the input register and then the four-entry result queue
// before its transaction. a byte leaves the input register only when the queue has room
// for two results, so ready on text_byte does not depend on ready on code_item.
// offsets, lines and columns saturate at the widths set by the parameters; outputs
// carry their low bits.
`default_nettype none

module utf8_decode_line_tracker
    import udlt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DFLT,  // 16 to 64
    parameter int LINE_WIDTH   = LINE_WIDTH_DFLT,    // 8 to 32
    parameter int COLUMN_WIDTH = COLUMN_WIDTH_DFLT   // 8 to 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    udlt_byte_if.sink    text_byte,
    udlt_point_if.source code_item
);

    // results of one byte, handed from the decoder to the queue
    push_t push;
    // queue can take a full pair this cycle
    logic  space_ok;

    // input register, sequence state, counters and the per-byte decode
    udlt_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_byte),
        .space_ok  (space_ok),
        .push      (push)
    );

    // result register queue, drained one transaction per cycle while code_item is ready
    udlt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .code_item (code_item)
    );

endmodule

`default_nettype wire

// ===== sv/udlt_core.sv =====
`default_nettype none
`include "utf8_decode_line_tracker_defines.svh"

module udlt_core
    import udlt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DFLT,
    parameter int LINE_WIDTH   = LINE_WIDTH_DFLT,
    parameter int COLUMN_WIDTH = COLUMN_WIDTH_DFLT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    udlt_byte_if.sink  text_byte,
    input  wire logic  space_ok,
    output push_t      push
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // decoder state
    logic [CP_W-1:0]         pv_reg,   pv_next;
    logic [1:0]              rem_reg,  rem_next;
    logic [OFFSET_WIDTH-1:0] boff_reg, boff_next;
    logic [OFFSET_WIDTH-1:0] uoff_reg, uoff_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [COLUMN_WIDTH-1:0] col_reg,  col_next;

    logic fire;
    logic take;

    // decode
    byte_class_t             cls;
    logic                    is_cont;
    logic [CP_W-1:0]         cut_cp, cont_cp, tail_cp, lead_bits;
    logic [1:0]              lead_len;
    logic                    tail_emit;
    logic                    v0, v1;
    logic [CP_W-1:0]         cp0, cp1;
    logic [OFFSET_WIDTH-1:0] end0, end1;
    logic [UNITS_W-1:0]      u0, u1;
    logic                    nl0, nl1;
    logic [OFFSET_WIDTH-1:0] uoff0, uoff1;
    logic [LINE_WIDTH-1:0]   line0, line1;
    logic [COLUMN_WIDTH-1:0] col0, col1;

    // assertion helpers
    logic                    pair_marks_ok;
    logic [OFFSET_WIDTH-1:0] boff_inc;

    function automatic logic [OFFSET_WIDTH-1:0] off_add(
        input logic [OFFSET_WIDTH-1:0] v,
        input logic [UNITS_W-1:0]      a
    );
        logic [OFFSET_WIDTH:0] s;
        s = {1'b0, v} + {{(OFFSET_WIDTH + 1 - UNITS_W){1'b0}}, a};
        return s[OFFSET_WIDTH] ? '1 : s[OFFSET_WIDTH-1:0];
    endfunction

    function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
        logic [LINE_WIDTH:0] s;
        s = {1'b0, v} + {{LINE_WIDTH{1'b0}}, 1'b1};
        return s[LINE_WIDTH] ? '1 : s[LINE_WIDTH-1:0];
    endfunction

    function automatic logic [COLUMN_WIDTH-1:0] col_add(
        input logic [COLUMN_WIDTH-1:0] v,
        input logic [UNITS_W-1:0]      a
    );
        logic [COLUMN_WIDTH:0] s;
        s = {1'b0, v} + {{(COLUMN_WIDTH + 1 - UNITS_W){1'b0}}, a};
        return s[COLUMN_WIDTH] ? '1 : s[COLUMN_WIDTH-1:0];
    endfunction

    assign fire           = in_valid_reg && space_ok;
    assign text_byte.ready = !in_valid_reg || fire;
    assign take           = text_byte.valid && text_byte.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= text_byte.data_byte;
            in_eos_reg  <= text_byte.end_of_stream;
        end
    end

    // byte classification and sequence handling
    always_comb
    begin
        cls       = classify(in_byte_reg);
        is_cont   = (cls == BC_CONT);
        cut_cp    = {pv_reg[CP_W-CP_SHIFT-1:0], {CP_SHIFT{1'b0}}};
        cont_cp   = {pv_reg[CP_W-CP_SHIFT-1:0], in_byte_reg[CP_SHIFT-1:0]};
        boff_next = off_add(boff_reg, UNITS_BMP);
        lead_bits = '0;
        lead_len  = 2'd0;
        tail_cp   = '0;
        tail_emit = 1'b0;

        unique case (cls)
            BC_ASCII:
            begin
                tail_cp   = CP_W'(in_byte_reg);
                tail_emit = 1'b1;
            end
            BC_CONT:
            begin
                // stray continuation gives zero
                tail_cp   = '0;
                tail_emit = 1'b1;
            end
            BC_LEAD2:
            begin
                lead_bits = CP_W'(in_byte_reg & LEAD2_MASK);
                lead_len  = 2'd1;
            end
            BC_LEAD3:
            begin
                lead_bits = CP_W'(in_byte_reg & LEAD3_MASK);
                lead_len  = 2'd2;
            end
            BC_LEAD4:
            begin
                lead_bits = CP_W'(in_byte_reg & LEAD4_MASK);
                lead_len  = 2'd3;
            end
            default:
            begin
                lead_bits = '0;
                lead_len  = 2'd0;
            end
        endcase

        if (!tail_emit && in_eos_reg)
        begin
            // lead byte at end of stream flushes its bits
            tail_cp   = lead_bits;
            tail_emit = 1'b1;
        end

        v1   = 1'b0;
        cp1  = tail_cp;
        end1 = boff_next;
        if (rem_reg != 2'd0 && is_cont)
        begin
            v0   = (rem_reg == 2'd1) || in_eos_reg;
            cp0  = cont_cp;
            end0 = boff_next;
            if (v0)
            begin
                pv_next  = '0;
                rem_next = 2'd0;
            end
            else
            begin
                pv_next  = cont_cp;
                rem_next = rem_reg - 2'd1;
            end
        end
        else
        begin
            if (rem_reg != 2'd0)
            begin
                // cut sequence: shifted partial first, then this byte if it yields a result
                v0   = 1'b1;
                cp0  = cut_cp;
                end0 = boff_reg;
                v1   = tail_emit;
            end
            else
            begin
                v0   = tail_emit;
                cp0  = tail_cp;
                end0 = boff_next;
            end
            if (tail_emit)
            begin
                pv_next  = '0;
                rem_next = 2'd0;
            end
            else
            begin
                pv_next  = lead_bits;
                rem_next = lead_len;
            end
        end
    end

    // position tracking across the two result slots
    always_comb
    begin
        u0    = units_of(cp0);
        nl0   = (cp0 == CP_W'(LF_CHAR));
        uoff0 = v0 ? off_add(uoff_reg, u0) : uoff_reg;
        line0 = (v0 && nl0) ? line_inc(line_reg) : line_reg;
        col0  = !v0 ? col_reg : (nl0 ? '0 : col_add(col_reg, u0));

        u1    = units_of(cp1);
        nl1   = (cp1 == CP_W'(LF_CHAR));
        uoff1 = v1 ? off_add(uoff0, u1) : uoff0;
        line1 = (v1 && nl1) ? line_inc(line0) : line0;
        col1  = !v1 ? col0 : (nl1 ? '0 : col_add(col0, u1));

        uoff_next = uoff1;
        line_next = line1;
        col_next  = col1;
    end

    always_comb
    begin
        push.n_items = fire ? {v1, v0 & !v1} : 2'd0;

        push.item0.cp_value         = cp0;
        push.item0.utf16_units      = u0;
        push.item0.utf8_end_offset  = OUT_OFF_W'(end0);
        push.item0.utf16_end_offset = OUT_OFF_W'(uoff0);
        push.item0.line_number      = OUT_LINE_W'(line0);
        push.item0.utf16_column     = OUT_COL_W'(col0);
        push.item0.is_newline       = nl0;
        push.item0.last_of_run      = !v1;

        push.item1.cp_value         = cp1;
        push.item1.utf16_units      = u1;
        push.item1.utf8_end_offset  = OUT_OFF_W'(end1);
        push.item1.utf16_end_offset = OUT_OFF_W'(uoff1);
        push.item1.line_number      = OUT_LINE_W'(line1);
        push.item1.utf16_column     = OUT_COL_W'(col1);
        push.item1.is_newline       = nl1;
        push.item1.last_of_run      = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            rem_reg  <= 2'd0;
            boff_reg <= '0;
            uoff_reg <= '0;
            line_reg <= '0;
            col_reg  <= '0;
        end
        else if (fire)
        begin
            pv_reg   <= pv_next;
            rem_reg  <= rem_next;
            boff_reg <= boff_next;
            uoff_reg <= uoff_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    assign pair_marks_ok = !push.item0.last_of_run && push.item1.last_of_run;
    assign boff_inc      = boff_reg + OFFSET_WIDTH'(1);

    `UDLT_ASSERT_IMPL(a_idle_pv_clear, rem_reg == 2'd0, pv_reg == '0, "stale partial value")
    `UDLT_ASSERT_IMPL(a_pair_order, push.n_items == 2'd2, pair_marks_ok, "pair marks wrong")
    `UDLT_ASSERT_NEXT(a_boff_inc, fire && !(&boff_reg), boff_reg == $past(boff_inc), "offset skip")

endmodule

`default_nettype wire

// ===== sv/udlt_out_fifo.sv =====
`default_nettype none
`include "utf8_decode_line_tracker_defines.svh"

module udlt_out_fifo
    import udlt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         space_ok,
    udlt_point_if.source code_item
);

    localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    out_item_t mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic                  pop;
    out_item_t             head;

    // assertion helpers
    logic                  drain_only;
    logic [FIFO_CNT_W-1:0] count_dec;

    // room for a full result pair
    assign space_ok = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop      = (count_reg != '0) && code_item.ready;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.n_items);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.n_items) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n_items != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push.n_items == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.item1;
        end
    end

    assign code_item.valid            = (count_reg != '0);
    assign code_item.cp_value         = head.cp_value;
    assign code_item.utf16_units      = head.utf16_units;
    assign code_item.utf8_end_offset  = head.utf8_end_offset;
    assign code_item.utf16_end_offset = head.utf16_end_offset;
    assign code_item.line_number      = head.line_number;
    assign code_item.utf16_column     = head.utf16_column;
    assign code_item.is_newline       = head.is_newline;
    assign code_item.last_of_run      = head.last_of_run;

    assign drain_only = pop && (push.n_items == 2'd0);
    assign count_dec  = count_reg - FIFO_CNT_W'(1);

    `UDLT_ASSERT_IMPL(a_no_overrun, push.n_items != 2'd0, space_ok, "queue overrun")
    `UDLT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_FULL, "count out of range")
    `UDLT_ASSERT_NEXT(a_drain_step, drain_only, count_reg == $past(count_dec), "missed drain")

endmodule

`default_nettype wire
